@@ sv/epo_pkg.sv @@
// Shared constants, types and helpers for the path odometer.
`timescale 1ns / 1ps
`default_nettype none

package epo_pkg;

  // Field widths
  localparam int POS_WIDTH = 24;
  localparam int FRAC_BITS = 4;
  localparam int ADD_W     = 24;
  localparam int MIN_W     = 16;
  localparam int CMD_W     = 3;
  localparam int STEP_W    = 25;
  localparam int LEN_W     = 32;
  localparam int ACC_W     = 48;

  // Datapath widths derived from the position width
  localparam int D_W   = POS_WIDTH + 1;   // |difference|
  localparam int SQ_W  = 2 * D_W;         // square of a difference
  localparam int R_W   = D_W;             // root width
  localparam int RAD_W = 2 * R_W;         // radicand width
  localparam int CNT_W = $clog2(R_W + 1);

  localparam logic [MIN_W-1:0]  MIN_RESET = MIN_W'(8);
  localparam logic [STEP_W-1:0] STEP_MAX  = {STEP_W{1'b1}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

  // One update request to the accumulator
  typedef struct packed {
    logic             go;
    logic [CMD_W-1:0] cmd;
    logic [R_W-1:0]   step;
    logic [ADD_W-1:0] add;
  } acc_op_t;

  // Clamp a root to the width of the step output field
  function automatic logic [STEP_W-1:0] step_sat(input logic [R_W-1:0] root);
    logic [63:0] w;
    w = 64'(root);
    if (w > 64'(STEP_MAX)) begin
      return STEP_MAX;
    end
    return STEP_W'(w);
  endfunction

endpackage

`default_nettype wire

@@ sv/epo_cfg_if.sv @@
// Configuration write channel carrying the dead-band register.
`timescale 1ns / 1ps
`default_nettype none

interface epo_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [epo_pkg::MIN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/epo_in_if.sv @@
// Input item channel: command and its operands.
`timescale 1ns / 1ps
`default_nettype none

interface epo_in_if;
  logic                                valid;
  logic                                ready;
  logic [epo_pkg::CMD_W-1:0]           cmd;
  logic signed [epo_pkg::POS_WIDTH-1:0] pos_x;
  logic signed [epo_pkg::POS_WIDTH-1:0] pos_y;
  logic signed [epo_pkg::ADD_W-1:0]    add_amount;

  modport source (output valid, output cmd, output pos_x, output pos_y,
                  output add_amount, input ready);
  modport sink   (input valid, input cmd, input pos_x, input pos_y,
                  input add_amount, output ready);
endinterface

`default_nettype wire

@@ sv/epo_out_if.sv @@
// Result item channel: path length, step distance and recording flag.
`timescale 1ns / 1ps
`default_nettype none

interface epo_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [epo_pkg::LEN_W-1:0] path_len;
  logic [epo_pkg::STEP_W-1:0]       step_dist;
  logic                             recording;

  modport source (output valid, output path_len, output step_dist,
                  output recording, input ready);
  modport sink   (input valid, input path_len, input step_dist,
                  input recording, output ready);
endinterface

`default_nettype wire

@@ sv/epo_sqrt.sv @@
// Digit-serial floor square root: two radicand bits in, one root bit out per cycle.
`timescale 1ns / 1ps
`default_nettype none

module epo_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [epo_pkg::RAD_W-1:0]   radicand,
  output logic                             done,
  output logic [epo_pkg::R_W-1:0]          root
);

  logic [epo_pkg::RAD_W-1:0] rad;
  logic [epo_pkg::R_W:0]     rem;     // partial remainder, up to 2*root
  logic [epo_pkg::CNT_W-1:0] cnt;

  logic [epo_pkg::R_W+2:0] rem_sh;
  logic [epo_pkg::R_W+2:0] trial;
  logic                    ge;

  // One restoring step: bring down a bit pair, try root*4+1
  always_comb begin
    rem_sh = {rem, rad[epo_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == epo_pkg::CNT_W'(1)) && !start;
      if (start) begin
        cnt <= epo_pkg::CNT_W'(epo_pkg::R_W);
      end else if (cnt != '0) begin
        cnt <= cnt - epo_pkg::CNT_W'(1);
      end
    end
  end

  // Shift registers for radicand, partial remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= rad << 2;
      rem  <= (epo_pkg::R_W+1)'(ge ? (rem_sh - trial) : rem_sh);
      root <= {root[epo_pkg::R_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ sv/epo_accum.sv @@
// Saturating 48-bit length accumulator, recording flag and whole-unit readout.
`timescale 1ns / 1ps
`default_nettype none

module epo_accum (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire epo_pkg::acc_op_t                 op,
  input  wire logic [epo_pkg::MIN_W-1:0]        min_step,
  output logic signed [epo_pkg::LEN_W-1:0]      path_len,
  output logic                                  recording
);

  localparam logic signed [epo_pkg::ACC_W-1:0] ACC_MAX =
    {1'b0, {(epo_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [epo_pkg::ACC_W-1:0] ACC_MIN =
    {1'b1, {(epo_pkg::ACC_W-1){1'b0}}};
  localparam logic signed [epo_pkg::ACC_W-1:0] BIAS =
    epo_pkg::ACC_W'((64'd1 << epo_pkg::FRAC_BITS) - 64'd1);
  localparam logic signed [epo_pkg::ACC_W-1:0] LEN_MAX =
    epo_pkg::ACC_W'({1'b0, {(epo_pkg::LEN_W-1){1'b1}}});
  localparam logic signed [epo_pkg::ACC_W-1:0] LEN_MIN =
    -LEN_MAX - epo_pkg::ACC_W'(1);

  logic signed [epo_pkg::ACC_W-1:0] acc;

  logic signed [epo_pkg::ACC_W-1:0] addend;
  logic signed [epo_pkg::ACC_W:0]   sum;
  logic signed [epo_pkg::ACC_W-1:0] sum_sat;
  logic                             above;
  logic signed [epo_pkg::ACC_W-1:0] q;

  // Saturating add of either the step or the signed direct amount
  always_comb begin
    if (op.cmd == epo_pkg::CMD_SAMPLE) begin
      addend = epo_pkg::ACC_W'(op.step);
    end else begin
      addend = epo_pkg::ACC_W'(signed'(op.add));
    end
    sum = {acc[epo_pkg::ACC_W-1], acc} + {addend[epo_pkg::ACC_W-1], addend};
    if (sum[epo_pkg::ACC_W] != sum[epo_pkg::ACC_W-1]) begin
      sum_sat = sum[epo_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[epo_pkg::ACC_W-1:0];
    end
    above = (op.step > epo_pkg::R_W'(min_step));
  end

  // Command decode
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      recording <= 1'b1;
    end else if (op.go) begin
      case (op.cmd)
        epo_pkg::CMD_SAMPLE: begin
          if (recording && above) begin
            acc <= sum_sat;
          end
        end
        epo_pkg::CMD_ADD: begin
          acc <= sum_sat;
        end
        epo_pkg::CMD_CLEAR: begin
          acc       <= '0;
          recording <= 1'b1;
        end
        epo_pkg::CMD_START: begin
          recording <= 1'b1;
        end
        epo_pkg::CMD_STOP: begin
          recording <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Whole units, truncated toward zero, clamped to 32 bits
  always_comb begin
    q = signed'(acc + (acc[epo_pkg::ACC_W-1] ? BIAS : '0)) >>> epo_pkg::FRAC_BITS;
    if (q > LEN_MAX) begin
      path_len = epo_pkg::LEN_W'(LEN_MAX);
    end else if (q < LEN_MIN) begin
      path_len = epo_pkg::LEN_W'(LEN_MIN);
    end else begin
      path_len = epo_pkg::LEN_W'(q);
    end
  end

endmodule

`default_nettype wire

@@ sv/euclidean_path_odometer.sv @@
// Top level of the Euclidean path odometer: command sequencer, squaring and output register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one command item at a time and returns one result item for each.
// For a position sample the step length is the floor square root of
// dx*dx + dy*dy, and the root unit resolves one bit per cycle of a root
// that is POS_WIDTH + 1 bits wide, then flags completion. Around it the
// sequencer takes the item with its difference, squares, loads the root
// unit, and after the root updates the accumulator and hands off to the
// output register. Every other command goes straight from acceptance to
// the accumulator update and the hand-off. The result sits in an output register,
// so the next item is taken while a result still waits to be read; the block
// stalls only when a new result is ready and the previous one is unread.
// The dead-band register may be written at any time the block is idle; its
// write channel is always ready.
module euclidean_path_odometer (
  input  wire logic clk,
  input  wire logic rst,
  epo_cfg_if.sink   cfg,
  epo_in_if.sink    din,
  epo_out_if.source dout
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [epo_pkg::MIN_W-1:0]     min_step;
  logic [epo_pkg::CMD_W-1:0]     cmd;
  logic [epo_pkg::ADD_W-1:0]     add;
  logic [epo_pkg::POS_WIDTH-1:0] prev_x;
  logic [epo_pkg::POS_WIDTH-1:0] prev_y;
  logic [epo_pkg::D_W-1:0]       ax;
  logic [epo_pkg::D_W-1:0]       ay;
  logic [epo_pkg::SQ_W-1:0]      sqx;
  logic [epo_pkg::SQ_W-1:0]      sqy;
  logic [epo_pkg::R_W-1:0]       step;

  logic [epo_pkg::D_W-1:0]       dx;
  logic [epo_pkg::D_W-1:0]       dy;
  logic                          in_fire;
  logic                          out_load;

  logic                          root_start;
  logic                          root_done;
  logic [epo_pkg::R_W-1:0]       root;
  logic [epo_pkg::RAD_W-1:0]     radicand;

  epo_pkg::acc_op_t              op;
  logic signed [epo_pkg::LEN_W-1:0] len_now;
  logic                          rec_now;

  // Config register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step <= epo_pkg::MIN_RESET;
    end else if (cfg.valid) begin
      min_step <= cfg.data;
    end
  end

  // Handshakes
  assign din.ready = (state == S_IDLE);
  assign in_fire   = din.valid && din.ready;
  assign out_load  = (state == S_DONE) && (!dout.valid || dout.ready);

  // Position differences, sign-extended by one bit
  always_comb begin
    dx = {din.pos_x[epo_pkg::POS_WIDTH-1], din.pos_x}
       - {prev_x[epo_pkg::POS_WIDTH-1], prev_x};
    dy = {din.pos_y[epo_pkg::POS_WIDTH-1], din.pos_y}
       - {prev_y[epo_pkg::POS_WIDTH-1], prev_y};
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (din.cmd == epo_pkg::CMD_SAMPLE) ? S_SQ : S_ACC;
        end
      end
      S_SQ:   state_next = S_SUM;
      S_SUM:  state_next = S_ROOT;
      S_ROOT: begin
        if (root_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      state <= state_next;
      if (in_fire && din.cmd == epo_pkg::CMD_SAMPLE) begin
        prev_x <= din.pos_x;
        prev_y <= din.pos_y;
      end
    end
  end

  // Item capture, magnitudes and squares
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd  <= din.cmd;
      add  <= din.add_amount;
      ax   <= dx[epo_pkg::D_W-1] ? (-dx) : dx;
      ay   <= dy[epo_pkg::D_W-1] ? (-dy) : dy;
      step <= '0;
    end
    if (state == S_SQ) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
    if (state == S_ROOT && root_done) begin
      step <= root;
    end
  end

  // Root unit
  assign root_start = (state == S_SUM);
  assign radicand   = sqx + sqy;

  epo_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  // Accumulator
  always_comb begin
    op.go   = (state == S_ACC);
    op.cmd  = cmd;
    op.step = step;
    op.add  = add;
  end

  epo_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .min_step  (min_step),
    .path_len  (len_now),
    .recording (rec_now)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (out_load) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dout.path_len  <= len_now;
      dout.step_dist <= epo_pkg::step_sat(step);
      dout.recording <= rec_now;
    end
  end

endmodule

`default_nettype wire

@@ dv/odometer_checker.sv @@
// Scoreboard for the path odometer: tracks odometer state and checks every result item.
`timescale 1ns / 1ps

module odometer_checker (
  input  wire logic clk,
  input  wire logic rst,
  epo_cfg_if        cfg,
  epo_in_if         din,
  epo_out_if        dout,
  output int        fail_count,
  output int        pending
);
  import epo_pkg::*;

  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint LEN_HI = (64'sd1 <<< (LEN_W - 1)) - 1;
  localparam longint LEN_LO = -LEN_HI - 1;

  typedef struct packed {
    logic signed [LEN_W-1:0] path_len;
    logic [STEP_W-1:0]       step_dist;
    logic                    recording;
  } odo_result_t;

  // Shadow copy of the odometer state
  logic [MIN_W-1:0]            dead_band;
  logic signed [POS_WIDTH-1:0] last_x;
  logic signed [POS_WIDTH-1:0] last_y;
  longint                      travel_acc;
  logic                        rec_on;
  odo_result_t                 expected_q[$];

  // Bitwise floor square root; the root of a 49-bit sum fits in 25 bits
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    int b;
    r = 0;
    for (b = D_W; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic longint clamp_acc(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // Apply one command item to the shadow state and form its result
  task automatic apply_item(input logic [CMD_W-1:0] cmd,
                            input logic signed [POS_WIDTH-1:0] x,
                            input logic signed [POS_WIDTH-1:0] y,
                            input logic signed [ADD_W-1:0] amount,
                            output odo_result_t res);
    longint dx;
    longint dy;
    longint q;
    longint unsigned step;
    step = 0;
    case (cmd)
      CMD_SAMPLE: begin
        dx = longint'(x) - longint'(last_x);
        dy = longint'(y) - longint'(last_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        step = floor_root(dx * dx + dy * dy);
        if (rec_on && step > 64'(dead_band))
          travel_acc = clamp_acc(travel_acc + $signed(step));
        last_x = x;
        last_y = y;
      end
      CMD_ADD:   travel_acc = clamp_acc(travel_acc + longint'(amount));
      CMD_CLEAR: begin
        travel_acc = 0;
        rec_on     = 1'b1;
      end
      CMD_START: rec_on = 1'b1;
      CMD_STOP:  rec_on = 1'b0;
      default:   ;
    endcase
    // whole units, truncated toward zero, then clamped to 32 bits
    q = travel_acc / (64'sd1 <<< FRAC_BITS);
    if (q > LEN_HI) q = LEN_HI;
    if (q < LEN_LO) q = LEN_LO;
    res.path_len  = LEN_W'(q);
    res.step_dist = (step > 64'(STEP_MAX)) ? STEP_MAX : STEP_W'(step);
    res.recording = rec_on;
  endtask

  // Compare results first, then queue the prediction for a new item
  always @(posedge clk) begin : monitor
    odo_result_t got;
    odo_result_t want;
    if (rst) begin
      dead_band  = MIN_RESET;
      last_x     = '0;
      last_y     = '0;
      travel_acc = 0;
      rec_on     = 1'b1;
      expected_q.delete();
      pending    = 0;
    end else begin
      if (dout.valid && dout.ready) begin
        got.path_len  = dout.path_len;
        got.step_dist = dout.step_dist;
        got.recording = dout.recording;
        if (expected_q.size() == 0) begin
          $error("result item with no expectation: path_len %0d", got.path_len);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.path_len !== want.path_len) begin
            $error("path_len mismatch: expected %0d, got %0d", want.path_len, got.path_len);
            fail_count++;
          end
          if (got.step_dist !== want.step_dist) begin
            $error("step_dist mismatch: expected %0d, got %0d",
                   want.step_dist, got.step_dist);
            fail_count++;
          end
          if (got.recording !== want.recording) begin
            $error("recording mismatch: expected %0b, got %0b",
                   want.recording, got.recording);
            fail_count++;
          end
        end
      end
      if (din.valid && din.ready) begin
        apply_item(din.cmd, din.pos_x, din.pos_y, din.add_amount, want);
        expected_q.push_back(want);
      end
      if (cfg.valid && cfg.ready) dead_band = cfg.data;
      pending = expected_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the path odometer: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import epo_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  localparam int POS_HI       = (1 << (POS_WIDTH - 1)) - 1;
  localparam int POS_LO       = -(1 << (POS_WIDTH - 1));
  localparam int ADD_HI       = (1 << (ADD_W - 1)) - 1;
  localparam int ADD_LO       = -(1 << (ADD_W - 1));
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 330;

  logic clk;
  logic rst;
  logic quiet;
  int   fails;
  int   pending;
  int   idle_cycles = 0;
  int   cur_x;
  int   cur_y;

  epo_cfg_if cfg_ch ();
  epo_in_if  in_ch ();
  epo_out_if out_ch ();

  euclidean_path_odometer u_top (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .din  (in_ch),
    .dout (out_ch)
  );

  odometer_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .din        (in_ch),
    .dout       (out_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Alternate stretches of random gaps with stretches of none
  initial begin
    quiet = 1'b0;
    forever begin
      repeat ($urandom_range(200, 800)) @(negedge clk);
      quiet = ~quiet;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic int rand_signed24();
    logic signed [POS_WIDTH-1:0] v;
    v = POS_WIDTH'($urandom);
    return int'(v);
  endfunction

  function automatic int clamp_pos(input int v);
    return (v > POS_HI) ? POS_HI : (v < POS_LO) ? POS_LO : v;
  endfunction

  // Result side: random stall before each item, then hold ready until taken
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one item; called and returning at a falling edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input int x, input int y,
                           input int amount);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd        <= cmd;
    in_ch.pos_x      <= POS_WIDTH'(x);
    in_ch.pos_y      <= POS_WIDTH'(y);
    in_ch.add_amount <= ADD_W'(amount);
    in_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_SAMPLE) begin
      cur_x = x;
      cur_y = y;
    end
  endtask

  task automatic sample(input int x, input int y);
    send_item(CMD_SAMPLE, x, y, rand_signed24());
  endtask

  task automatic add_len(input int amount);
    send_item(CMD_ADD, rand_signed24(), rand_signed24(), amount);
  endtask

  task automatic command(input logic [CMD_W-1:0] cmd);
    send_item(cmd, rand_signed24(), rand_signed24(), rand_signed24());
  endtask

  task automatic write_min_step(input logic [MIN_W-1:0] value);
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid and hold off until every result is back, plus some margin
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Mostly path-like samples near the last position, plus the other commands
  task automatic random_item();
    int pick;
    int span;
    int dx;
    int dy;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      span = ($urandom_range(0, 3) == 0) ? 4096 : 48;
      dx   = int'($urandom_range(0, 2 * span)) - span;
      dy   = int'($urandom_range(0, 2 * span)) - span;
      sample(clamp_pos(cur_x + dx), clamp_pos(cur_y + dy));
    end else if (pick < 68) begin
      sample(rand_signed24(), rand_signed24());
    end else if (pick < 78) begin
      add_len(rand_signed24());
    end else if (pick < 84) begin
      add_len(int'($urandom_range(0, 64)) - 32);
    end else if (pick < 89) begin
      command(CMD_STOP);
    end else if (pick < 95) begin
      command(CMD_START);
    end else if (pick < 97) begin
      command(CMD_CLEAR);
    end else begin
      command(CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)));
    end
  endtask

  initial begin : stimulus
    logic [MIN_W-1:0] dead_band [4];
    int ph;
    int n;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_SAMPLE;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.add_amount = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    cur_x            = 0;
    cur_y            = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: dead band edge, extreme steps, recording control, adds, unused codes
    sample(0, 0);
    sample(8, 0);                 // exactly at the dead band: not counted
    sample(17, 0);                // one above: counted
    sample(17, 9);
    sample(POS_HI, POS_HI);
    sample(POS_LO, POS_LO);       // longest possible step
    sample(POS_LO, POS_HI);
    sample(POS_HI, POS_LO);
    command(CMD_STOP);
    sample(0, 0);                 // not counted while stopped
    command(CMD_STOP);
    command(CMD_START);
    sample(-3, -4);
    add_len(ADD_HI);
    add_len(ADD_LO);
    add_len(-1);
    add_len(0);
    command(CMD_CLEAR);
    add_len(-17);                 // rounds toward zero
    command(CMD_STOP);
    command(CMD_CLEAR);           // clear also restarts recording
    command(CMD_RSVD_LO);
    command(CMD_W'(6));
    command(CMD_RSVD_HI);
    settle(DRAIN_CYCLES);

    // Random phases, each under its own dead band
    dead_band[0] = '0;
    dead_band[1] = '1;
    dead_band[2] = MIN_W'($urandom_range(1, 64));
    dead_band[3] = MIN_W'($urandom);
    for (ph = 0; ph < 4; ph++) begin
      write_min_step(dead_band[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) settle(0);
        random_item();
      end
      settle(DRAIN_CYCLES);
    end

    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
